// File: sv/cidx_pkg.sv
// ----------------------------------------------------------------------------
// cidx_pkg
// shared types and constants for the concat index to offset generator
// ----------------------------------------------------------------------------
package cidx_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned DivSteps   = DataW;
  localparam int unsigned MaxDimsDef = 3;
  localparam int unsigned AddrW      = 5;

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [2:0] {
    RegDimsInUse  = 3'd0,
    RegCatDim     = 3'd1,
    RegOutSize1   = 3'd2,
    RegOutSize2   = 3'd3,
    RegOutStride0 = 3'd4,
    RegOutStride1 = 3'd5,
    RegOutStride2 = 3'd6,
    RegCatStride  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    word_t stride_0;
    word_t stride_1;
    word_t stride_2;
    word_t cat_stride;
  } strides_t;

endpackage

// File: sv/cidx_div.sv
// ----------------------------------------------------------------------------
// cidx_div
// pipelined restoring divider, one quotient bit per stage, with side payload
// ----------------------------------------------------------------------------
module cidx_div #(
  parameter int unsigned PayW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  cidx_pkg::word_t      dividend_i,
  input  cidx_pkg::word_t      divisor_i,
  input  logic [PayW-1:0]      pay_i,
  output logic                 vld_o,
  output cidx_pkg::word_t      quo_o,
  output cidx_pkg::word_t      rem_o,
  output logic                 dz_o,
  output logic [PayW-1:0]      pay_o
);
  import cidx_pkg::*;

  logic            vld_q [1:DivSteps];
  word_t           n_q   [1:DivSteps];
  word_t           r_q   [1:DivSteps];
  word_t           d_q   [1:DivSteps];
  logic [PayW-1:0] pay_q [1:DivSteps];

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic            vld_p;
    word_t           n_p, r_p, d_p;
    logic [PayW-1:0] pay_p;
    logic [DataW:0]  t, diff;
    logic            ge;
    word_t           n_d, r_d;

    if (k == 1) begin : g_first
      assign vld_p = vld_i;
      assign n_p   = dividend_i;
      assign r_p   = '0;
      assign d_p   = divisor_i;
      assign pay_p = pay_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign n_p   = n_q[k-1];
      assign r_p   = r_q[k-1];
      assign d_p   = d_q[k-1];
      assign pay_p = pay_q[k-1];
    end

    always_comb begin
      t    = {r_p, n_p[DataW-1]};
      diff = t - {1'b0, d_p};
      ge   = (t >= {1'b0, d_p});
      r_d  = ge ? diff[DataW-1:0] : t[DataW-1:0];
      n_d  = {n_p[DataW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]   <= n_d;
        r_q[k]   <= r_d;
        d_q[k]   <= d_p;
        pay_q[k] <= pay_p;
      end
    end
  end

  assign vld_o = vld_q[DivSteps];
  assign quo_o = n_q[DivSteps];
  assign rem_o = r_q[DivSteps];
  assign dz_o  = (d_q[DivSteps] == '0);
  assign pay_o = pay_q[DivSteps];

endmodule

// File: sv/cidx_sum.sv
// ----------------------------------------------------------------------------
// cidx_sum
// scales the digits by their strides and the base position by the concat stride, then adds the products
// ----------------------------------------------------------------------------
module cidx_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  cidx_pkg::word_t     dig0_i,
  input  cidx_pkg::word_t     dig1_i,
  input  cidx_pkg::word_t     dig2_i,
  input  cidx_pkg::word_t     base_i,
  input  cidx_pkg::strides_t  strides_i,
  output logic                vld_o,
  output cidx_pkg::word_t     offset_o
);
  import cidx_pkg::*;

  logic  prod_vld_q, sum_vld_q;
  word_t p0_q, p1_q, p2_q, pb_q;
  word_t p0_d, p1_d, p2_d, pb_d;
  word_t sum_d, sum_q;

  always_comb begin
    p0_d  = DataW'(dig0_i * strides_i.stride_0);
    p1_d  = DataW'(dig1_i * strides_i.stride_1);
    p2_d  = DataW'(dig2_i * strides_i.stride_2);
    pb_d  = DataW'(base_i * strides_i.cat_stride);
    sum_d = p0_q + p1_q + p2_q + pb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
    end else if (en_i) begin
      prod_vld_q <= vld_i;
      sum_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      pb_q  <= pb_d;
      sum_q <= sum_d;
    end
  end

  assign vld_o    = sum_vld_q;
  assign offset_o = sum_q;

endmodule

// File: sv/concat_index_to_offset.sv
// ----------------------------------------------------------------------------
// concat_index_to_offset
// output offset generator for tensor concatenation
// ----------------------------------------------------------------------------
// input channel: element_index, slice_size and base_position per beat, taken
// when in_valid_i is high and in_stall_o is low. output channel: one
// out_offset per input beat, in order, taken when out_valid_o is high and
// out_stall_i is low.
// the pipeline is two 32-stage divider pipelines (dimension
// two, then dimension one), a product stage and a sum stage. throughput is
// one beat per cycle while the output is not stalled.
// a stalled result freezes the whole pipeline; in_stall_o follows
// out_stall_i while a result waits, so nothing is dropped or repeated.
// reset empties the pipeline and loads the register defaults (one dimension,
// concatenation on dimension zero, sizes and strides of one).
// registers sit on the apb port at byte address 4*index; pready is always
// high and writes land in the access cycle. write only while idle.
// ----------------------------------------------------------------------------
module concat_index_to_offset #(
  parameter int unsigned MaxDims = cidx_pkg::MaxDimsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cidx_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  element_index_i,
  input  logic [31:0]                  slice_size_i,
  input  logic [31:0]                  base_position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  out_offset_o
);
  import cidx_pkg::*;

  logic [1:0] dims_q, cat_dim_q;
  word_t      size1_q, size2_q, stride0_q, stride1_q, stride2_q, cat_stride_q;
  reg_idx_e   widx;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q       <= 2'd1;
      cat_dim_q    <= 2'd0;
      size1_q      <= 32'd1;
      size2_q      <= 32'd1;
      stride0_q    <= 32'd1;
      stride1_q    <= 32'd1;
      stride2_q    <= 32'd1;
      cat_stride_q <= 32'd1;
    end else if (wr_en) begin
      case (widx)
        RegDimsInUse:  dims_q       <= pwdata[1:0];
        RegCatDim:     cat_dim_q    <= pwdata[1:0];
        RegOutSize1:   size1_q      <= pwdata;
        RegOutSize2:   size2_q      <= pwdata;
        RegOutStride0: stride0_q    <= pwdata;
        RegOutStride1: stride1_q    <= pwdata;
        RegOutStride2: stride2_q    <= pwdata;
        RegCatStride:  cat_stride_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      RegDimsInUse:  prdata = {30'd0, dims_q};
      RegCatDim:     prdata = {30'd0, cat_dim_q};
      RegOutSize1:   prdata = size1_q;
      RegOutSize2:   prdata = size2_q;
      RegOutStride0: prdata = stride0_q;
      RegOutStride1: prdata = stride1_q;
      RegOutStride2: prdata = stride2_q;
      RegCatStride:  prdata = cat_stride_q;
      default:       prdata = '0;
    endcase
  end

  // effective dimension count
  logic [1:0] dims_eff;
  logic       act2, act1;

  always_comb begin
    if (dims_q == 2'd0) begin
      dims_eff = 2'd1;
    end else if (dims_q > 2'(MaxDims)) begin
      dims_eff = 2'(MaxDims);
    end else begin
      dims_eff = dims_q;
    end
    act2 = (dims_eff == 2'd3);
    act1 = (dims_eff >= 2'd2);
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // dimension two
  word_t           rad2;
  logic            a_vld, a_dz;
  word_t           a_quo, a_rem;
  logic [63:0]     a_pay;

  assign rad2 = act2 ? ((cat_dim_q == 2'd2) ? slice_size_i : size2_q) : '0;

  cidx_div #(.PayW(64)) u_div2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (in_valid_i),
    .dividend_i (element_index_i),
    .divisor_i  (rad2),
    .pay_i      ({slice_size_i, base_position_i}),
    .vld_o      (a_vld),
    .quo_o      (a_quo),
    .rem_o      (a_rem),
    .dz_o       (a_dz),
    .pay_o      (a_pay)
  );

  // dimension one
  word_t       carry2, dig2, rad1, a_slice, a_base;
  logic        b_vld, b_dz;
  word_t       b_quo, b_rem;
  logic [63:0] b_pay;

  always_comb begin
    a_slice = a_pay[63:32];
    a_base  = a_pay[31:0];
    carry2  = act2 ? (a_dz ? '0 : a_quo) : a_rem;
    dig2    = act2 ? a_rem : '0;
    rad1    = act1 ? ((cat_dim_q == 2'd1) ? a_slice : size1_q) : '0;
  end

  cidx_div #(.PayW(64)) u_div1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (a_vld),
    .dividend_i (carry2),
    .divisor_i  (rad1),
    .pay_i      ({dig2, a_base}),
    .vld_o      (b_vld),
    .quo_o      (b_quo),
    .rem_o      (b_rem),
    .dz_o       (b_dz),
    .pay_o      (b_pay)
  );

  word_t    dig0, dig1;
  strides_t strides;

  always_comb begin
    dig0                = act1 ? (b_dz ? '0 : b_quo) : b_rem;
    dig1                = act1 ? b_rem : '0;
    strides.stride_0    = stride0_q;
    strides.stride_1    = stride1_q;
    strides.stride_2    = stride2_q;
    strides.cat_stride  = cat_stride_q;
  end

  cidx_sum u_sum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (b_vld),
    .dig0_i    (dig0),
    .dig1_i    (dig1),
    .dig2_i    (b_pay[63:32]),
    .base_i    (b_pay[31:0]),
    .strides_i (strides),
    .vld_o     (out_valid_o),
    .offset_o  (out_offset_o)
  );

endmodule

// File: sv/cidx_checker.sv
// ----------------------------------------------------------------------------
// cidx_checker
// port-level checks for the concat index to offset generator
// ----------------------------------------------------------------------------
module cidx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_offset_o
);

  a_stall_only_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("input stalled without a blocked result");

  a_blocked_stalls_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |-> in_stall_o
  ) else $error("input taken while the result is blocked");

  a_hold_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o
  ) else $error("stalled beat dropped");

  a_hold_data: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=> $stable(out_offset_o)
  ) else $error("stalled beat changed");

  a_pready: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pready
  ) else $error("pready low");

endmodule

bind concat_index_to_offset cidx_checker u_cidx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_offset_o (out_offset_o)
);
